@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants and operation/status codes of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int COUNT_W = 6;
    localparam int STAT_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_VIEW       = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_PUSH_BACK  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_POP_FRONT  = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

@@ hdl/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// valid/ready channels for queue requests and queue results
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::FUNC_W-1:0]           func;
    logic signed [deq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::VALUE_W-1:0]   item_value;
    logic [deq_pkg::COUNT_W-1:0]          entry_count;
    logic                                 last;
    logic [deq_pkg::STAT_W-1:0]           status;

    modport source (output valid, output item_value, output entry_count,
                    output last, output status, input ready);
    modport sink   (input valid, input item_value, input entry_count,
                    input last, input status, output ready);
endinterface

@@ hdl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of signed 32-bit values kept as a ring in a ram
// ----------------------------------------------------------------------------
// A push, a refused push or an empty pop loads its result into the output
// register directly; an unknown operation gives no result and changes nothing.
// A pop's removed value comes out of the single registered read port of the
// entry ram in the cycle after the request transfer. A view reads the stored
// entries in order, one read per cycle while the output register is free, and
// each result is loaded as the next read goes out. One request is in work at a
// time, and a new request is taken only when the output register is free or
// being emptied in the same cycle. No clearing pass follows reset.
module double_ended_queue_unit (
    input  logic         clk,
    input  logic         rst_n,
    deq_req_if.sink      req,
    deq_rsp_if.source    rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_VIEW
    } state_t;

    state_t                                state_reg, state_next;
    logic [deq_pkg::IDX_W-1:0]             front_reg, front_next;
    logic [deq_pkg::CNT_W-1:0]             count_reg, count_next;
    logic [deq_pkg::CNT_W-1:0]             idx_reg, idx_next;

    logic                                  out_valid_reg, out_valid_next;
    logic signed [deq_pkg::VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [deq_pkg::COUNT_W-1:0]           out_count_reg, out_count_next;
    logic                                  out_last_reg, out_last_next;
    logic [deq_pkg::STAT_W-1:0]            out_status_reg, out_status_next;

    logic                                  ram_we;
    logic [deq_pkg::IDX_W-1:0]             ram_waddr;
    logic [deq_pkg::VALUE_W-1:0]           ram_wdata;
    logic                                  ram_re;
    logic [deq_pkg::IDX_W-1:0]             ram_raddr;
    logic [deq_pkg::VALUE_W-1:0]           ram_rdata;

    logic                                  out_free;
    logic                                  req_fire;
    logic                                  view_last;
    logic [deq_pkg::IDX_W-1:0]             new_front;

    // ring index add, both operands below DEPTH
    function automatic logic [deq_pkg::IDX_W-1:0] slot_add(
        input logic [deq_pkg::IDX_W-1:0] a,
        input logic [deq_pkg::IDX_W-1:0] b
    );
        logic [deq_pkg::IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (deq_pkg::IDX_W + 1)'(deq_pkg::DEPTH))
        begin
            s = s - (deq_pkg::IDX_W + 1)'(deq_pkg::DEPTH);
        end
        return s[deq_pkg::IDX_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (deq_pkg::VALUE_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;
    assign view_last = (idx_reg == count_reg - deq_pkg::CNT_W'(1));
    assign new_front = (front_reg == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
                                         : front_reg - deq_pkg::IDX_W'(1);

    assign rsp.valid       = out_valid_reg;
    assign rsp.item_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.status      = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_add(front_reg, deq_pkg::IDX_W'(count_reg));
        ram_wdata       = req.value;
        ram_re          = 1'b0;
        ram_raddr       = front_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.func)
                        deq_pkg::FUNC_VIEW:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                                out_status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                idx_next   = '0;
                                state_next = ST_VIEW;
                            end
                        end
                        deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_last_next  = 1'b1;
                            if (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH))
                            begin
                                out_count_next  = deq_pkg::COUNT_W'(count_reg);
                                out_status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (req.func == deq_pkg::FUNC_PUSH_FRONT)
                                begin
                                    ram_waddr  = new_front;
                                    front_next = new_front;
                                end
                                count_next      = count_reg + deq_pkg::CNT_W'(1);
                                out_count_next  = deq_pkg::COUNT_W'(count_next);
                                out_status_next = deq_pkg::STAT_OK;
                            end
                        end
                        deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                                out_status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                if (req.func == deq_pkg::FUNC_POP_BACK)
                                begin
                                    ram_raddr = slot_add(front_reg, deq_pkg::IDX_W'(
                                        count_reg - deq_pkg::CNT_W'(1)));
                                end
                                else
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = slot_add(front_reg, deq_pkg::IDX_W'(1));
                                end
                                count_next = count_reg - deq_pkg::CNT_W'(1);
                                state_next = ST_POP;
                            end
                        end
                        default:
                        begin
                            // unknown operation: no result, no change
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = $signed(ram_rdata);
                    out_count_next  = deq_pkg::COUNT_W'(count_reg);
                    out_last_next   = 1'b1;
                    out_status_next = deq_pkg::STAT_OK;
                    state_next      = ST_IDLE;
                end
            end
            ST_VIEW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = $signed(ram_rdata);
                    out_count_next  = deq_pkg::COUNT_W'(count_reg);
                    out_last_next   = view_last;
                    out_status_next = deq_pkg::STAT_OK;
                    if (view_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry while this one goes out
                        idx_next  = idx_reg + deq_pkg::CNT_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = slot_add(front_reg, deq_pkg::IDX_W'(idx_next));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= deq_pkg::STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

@@ verif/double_ended_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// self-checking bench for the bounded double-ended queue: drives push, pop,
// view and unused operation codes through the request channel, predicts every
// result with a ring model of its own, and checks each result transfer field
// by field while both channels idle and stall in random bursts
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

    localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_LO  = 3'd5;
    localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_MID = 3'd6;
    localparam logic [deq_pkg::FUNC_W-1:0] FUNC_UNKNOWN_HI  = 3'd7;
    localparam int SETTLE_CYCLES = 2 * deq_pkg::DEPTH + 8;

    typedef struct {
        logic signed [deq_pkg::VALUE_W-1:0] item_value;
        logic [deq_pkg::COUNT_W-1:0]        entry_count;
        logic                               last;
        logic [deq_pkg::STAT_W-1:0]         status;
    } deq_result_t;

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ring model of the queue contents
    logic signed [deq_pkg::VALUE_W-1:0] ring_entries [deq_pkg::DEPTH];
    int unsigned                        ring_front;
    int unsigned                        ring_count;

    deq_result_t expected_results [$];
    deq_result_t oldest_result;

    bit idle_enable = 1'b1;
    int error_count;
    int request_count;
    int result_count;
    int view_count;
    int refused_push_count;
    int empty_report_count;
    int stall_left;

    initial begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic void add_result(logic signed [deq_pkg::VALUE_W-1:0] v,
                                       int unsigned cnt, logic lst,
                                       logic [deq_pkg::STAT_W-1:0] st);
        deq_result_t r;
        r.item_value  = v;
        r.entry_count = cnt[deq_pkg::COUNT_W-1:0];
        r.last        = lst;
        r.status      = st;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_queue_op(logic [deq_pkg::FUNC_W-1:0] f,
                                             logic signed [deq_pkg::VALUE_W-1:0] v);
        int unsigned pos;
        request_count++;
        case (f)
            deq_pkg::FUNC_VIEW:
            begin
                view_count++;
                if (ring_count == 0)
                begin
                    empty_report_count++;
                    add_result('0, 0, 1'b1, deq_pkg::STAT_EMPTY);
                end
                else
                begin
                    for (int unsigned i = 0; i < ring_count; i++)
                    begin
                        add_result(ring_entries[(ring_front + i) % deq_pkg::DEPTH],
                                   ring_count, i + 1 == ring_count, deq_pkg::STAT_OK);
                    end
                end
            end
            deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK:
            begin
                if (ring_count >= deq_pkg::DEPTH)
                begin
                    refused_push_count++;
                    add_result('0, ring_count, 1'b1, deq_pkg::STAT_FULL);
                end
                else
                begin
                    if (f == deq_pkg::FUNC_PUSH_FRONT)
                    begin
                        ring_front = (ring_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                        ring_entries[ring_front] = v;
                    end
                    else
                    begin
                        ring_entries[(ring_front + ring_count) % deq_pkg::DEPTH] = v;
                    end
                    ring_count++;
                    add_result('0, ring_count, 1'b1, deq_pkg::STAT_OK);
                end
            end
            deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_POP_FRONT:
            begin
                if (ring_count == 0)
                begin
                    empty_report_count++;
                    add_result('0, 0, 1'b1, deq_pkg::STAT_EMPTY);
                end
                else
                begin
                    if (f == deq_pkg::FUNC_POP_BACK)
                    begin
                        pos = (ring_front + ring_count - 1) % deq_pkg::DEPTH;
                    end
                    else
                    begin
                        pos = ring_front;
                        ring_front = (ring_front + 1) % deq_pkg::DEPTH;
                    end
                    ring_count--;
                    add_result(ring_entries[pos], ring_count, 1'b1, deq_pkg::STAT_OK);
                end
            end
            default:
            begin
                // unused codes are dropped without a result
            end
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [deq_pkg::FUNC_W-1:0] f,
                                input logic signed [deq_pkg::VALUE_W-1:0] v);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        predict_queue_op(f, v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_results.size() != 0);
    endtask

    function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::FUNC_W-1:0] pick_func();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 24) return deq_pkg::FUNC_PUSH_FRONT;
        if (roll < 48) return deq_pkg::FUNC_PUSH_BACK;
        if (roll < 68) return deq_pkg::FUNC_POP_BACK;
        if (roll < 88) return deq_pkg::FUNC_POP_FRONT;
        if (roll < 94) return deq_pkg::FUNC_VIEW;
        return deq_pkg::FUNC_W'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
    endfunction

    task automatic test_empty_queue();
        send_request(deq_pkg::FUNC_VIEW, 32'sd0);
        send_request(deq_pkg::FUNC_POP_BACK, 32'sh7fff_ffff);
        send_request(deq_pkg::FUNC_POP_FRONT, -32'sd1);
        send_request(FUNC_UNKNOWN_LO, 32'sh1234_5678);
        send_request(FUNC_UNKNOWN_HI, -32'sd1);
        send_request(FUNC_UNKNOWN_MID, 32'sd0);
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_request(deq_pkg::FUNC_PUSH_FRONT, 32'sh8000_0000);
        send_request(deq_pkg::FUNC_PUSH_BACK, 32'sh7fff_ffff);
        send_request(deq_pkg::FUNC_PUSH_BACK, 32'sd0);
        send_request(deq_pkg::FUNC_PUSH_FRONT, -32'sd1);
        send_request(deq_pkg::FUNC_PUSH_BACK, 32'shaaaa_aaaa);
        send_request(deq_pkg::FUNC_PUSH_FRONT, 32'sh5555_5555);
        send_request(deq_pkg::FUNC_VIEW, 32'sd0);
        send_request(deq_pkg::FUNC_POP_FRONT, 32'sd0);
        send_request(deq_pkg::FUNC_POP_BACK, 32'sd0);
        send_request(deq_pkg::FUNC_POP_BACK, 32'sd0);
        send_request(deq_pkg::FUNC_POP_FRONT, 32'sd0);
        send_request(deq_pkg::FUNC_VIEW, 32'sd0);
        wait_drained();
    endtask

    // fill to the brim, bounce pushes off both ends, view it all, empty it, pop once more
    task automatic test_full_queue();
        while (ring_count < deq_pkg::DEPTH)
        begin
            send_request($urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_FRONT
                                              : deq_pkg::FUNC_PUSH_BACK,
                         pick_value());
        end
        send_request(deq_pkg::FUNC_PUSH_FRONT, pick_value());
        send_request(deq_pkg::FUNC_PUSH_BACK, pick_value());
        send_request(deq_pkg::FUNC_VIEW, 32'sd0);
        while (ring_count > 0)
        begin
            send_request($urandom_range(0, 1) ? deq_pkg::FUNC_POP_FRONT
                                              : deq_pkg::FUNC_POP_BACK,
                         pick_value());
        end
        send_request(deq_pkg::FUNC_POP_BACK, 32'sd0);
        wait_drained();
    endtask

    task automatic test_random_mix(input int n);
        repeat (n)
        begin
            send_request(pick_func(), pick_value());
        end
        wait_drained();
    endtask

    // last part: no idling on either side
    task automatic test_back_to_back(input int n);
        idle_enable = 1'b0;
        repeat (n)
        begin
            send_request(pick_func(), pick_value());
        end
        send_request(deq_pkg::FUNC_VIEW, 32'sd0);
        wait_drained();
    endtask

    task automatic compare_field(input string field,
                                 input logic [deq_pkg::VALUE_W-1:0] want,
                                 input logic [deq_pkg::VALUE_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual value %h count %0d",
                         $time, rsp_ch.item_value, rsp_ch.entry_count);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                compare_field("item_value",
                              deq_pkg::VALUE_W'(oldest_result.item_value),
                              deq_pkg::VALUE_W'(rsp_ch.item_value));
                compare_field("entry_count",
                              deq_pkg::VALUE_W'(oldest_result.entry_count),
                              deq_pkg::VALUE_W'(rsp_ch.entry_count));
                compare_field("last",
                              deq_pkg::VALUE_W'(oldest_result.last),
                              deq_pkg::VALUE_W'(rsp_ch.last));
                compare_field("status",
                              deq_pkg::VALUE_W'(oldest_result.status),
                              deq_pkg::VALUE_W'(rsp_ch.status));
            end
        end
    end

    // result-side stalls in random bursts
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (idle_enable && stall_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12);
            end
            if (idle_enable && stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = deq_pkg::FUNC_VIEW;
        req_ch.value = '0;
        ring_front   = 0;
        ring_count   = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_extreme_values();
        test_full_queue();
        test_random_mix(40);
        test_back_to_back(25);

        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d requests and %0d results: %0d views, %0d refused pushes,",
                 request_count, result_count, view_count, refused_push_count);
        $display("%0d empty-queue reports, fill to depth %0d and unused operation codes",
                 empty_report_count, deq_pkg::DEPTH);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
